/* rtl/core/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA package
// Shared widths, constants, payload types and the round mix function.
// ----------------------------------------------------------------------------
package xtea_pkg;

   localparam int WORD_WIDTH    = 32;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_IDX_WIDTH = $clog2(KEY_WORDS);
   localparam int ROUNDS_DEF    = 32;

   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E37_79B9;

   // bit positions of the key index in the second half-round
   localparam int KEY_SEL_HI_LSB = 11;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [KEY_IDX_WIDTH-1:0] key_idx_type;
   typedef word_type [KEY_WORDS-1:0] key_array_type;

   typedef enum logic {
      CMD_ENCIPHER = 1'b0,
      CMD_DECIPHER = 1'b1
   } cmd_type;

   // one block traveling down the pipeline
   typedef struct packed {
      cmd_type  cmd;
      word_type v0;
      word_type v1;
   } block_type;

   function automatic word_type mix(input word_type x);
      mix = ((x << 4) ^ (x >> 5)) + x;
   endfunction

endpackage

/* rtl/core/xtea_req_if.sv */
// ----------------------------------------------------------------------------
// XTEA request channel
// Valid/ready channel that carries one plaintext or ciphertext word.
// ----------------------------------------------------------------------------
interface xtea_req_if;
   import xtea_pkg::*;

   logic     valid;
   logic     ready;
   logic     command;
   word_type first_half;
   word_type second_half;

   modport source (output valid, output command, output first_half,
                   output second_half, input ready);
   modport sink   (input valid, input command, input first_half,
                   input second_half, output ready);
endinterface

/* rtl/core/xtea_rsp_if.sv */
// ----------------------------------------------------------------------------
// XTEA response channel
// Valid/ready channel that carries one processed word.
// ----------------------------------------------------------------------------
interface xtea_rsp_if;
   import xtea_pkg::*;

   logic     valid;
   logic     ready;
   word_type out_first_half;
   word_type out_second_half;

   modport source (output valid, output out_first_half, output out_second_half,
                   input ready);
   modport sink   (input valid, input out_first_half, input out_second_half,
                   output ready);
endinterface

/* rtl/core/xtea_keys.sv */
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the CSR port.
// ----------------------------------------------------------------------------
module xtea_keys (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  xtea_pkg::key_idx_type  csr_index,
   input  xtea_pkg::word_type     csr_wdata,
   output xtea_pkg::key_array_type key
);
   import xtea_pkg::*;

   key_array_type key_ff;
   key_array_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         key_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

/* rtl/core/xtea_stage.sv */
// ----------------------------------------------------------------------------
// XTEA pipeline stage
// One registered half-round; sum and key index are fixed per stage.
// ----------------------------------------------------------------------------
module xtea_stage #(
   parameter int STAGE  = 0,
   parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic                    in_valid,
   input  xtea_pkg::block_type     in_block,
   input  xtea_pkg::key_array_type key,
   output logic                    out_valid,
   output xtea_pkg::block_type     out_block
);
   import xtea_pkg::*;

   localparam int   PAIR     = STAGE / 2;
   localparam logic ODD_BIT  = 1'(STAGE % 2);
   localparam int   ENC_MULT = (STAGE % 2 != 0) ? PAIR + 1 : PAIR;
   localparam int   DEC_MULT = (STAGE % 2 != 0) ? ROUNDS - PAIR - 1 : ROUNDS - PAIR;
   localparam logic [2*WORD_WIDTH-1:0] ENC_PROD = 64'(ENC_MULT) * 64'(DELTA);
   localparam logic [2*WORD_WIDTH-1:0] DEC_PROD = 64'(DEC_MULT) * 64'(DELTA);
   localparam word_type ENC_SUM = ENC_PROD[WORD_WIDTH-1:0];
   localparam word_type DEC_SUM = DEC_PROD[WORD_WIDTH-1:0];
   localparam key_idx_type ENC_IDX = (STAGE % 2 != 0) ?
      ENC_SUM[KEY_SEL_HI_LSB +: KEY_IDX_WIDTH] : ENC_SUM[KEY_IDX_WIDTH-1:0];
   localparam key_idx_type DEC_IDX = (STAGE % 2 != 0) ?
      DEC_SUM[KEY_IDX_WIDTH-1:0] : DEC_SUM[KEY_SEL_HI_LSB +: KEY_IDX_WIDTH];

   logic        valid_ff;
   block_type   block_ff;
   block_type   block_in;
   logic        dec;
   logic        upd_v0;
   word_type    src;
   word_type    dst;
   word_type    sum_key;
   word_type    f;
   word_type    res;

   // even stages of encipher and odd stages of decipher update v0
   always_comb begin
      dec     = (in_block.cmd == CMD_DECIPHER);
      upd_v0  = dec ~^ ODD_BIT;
      src     = upd_v0 ? in_block.v1 : in_block.v0;
      dst     = upd_v0 ? in_block.v0 : in_block.v1;
      sum_key = dec ? (DEC_SUM + key[DEC_IDX]) : (ENC_SUM + key[ENC_IDX]);
      f       = mix(src) ^ sum_key;
      res     = dec ? (dst - f) : (dst + f);
      block_in     = in_block;
      block_in.v0  = upd_v0 ? res : in_block.v0;
      block_in.v1  = upd_v0 ? in_block.v1 : res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         block_ff <= block_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_block = block_ff;

endmodule

/* rtl/core/xtea_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// XTEA block cipher
// XTEA encipher or decipher of a 64-bit word under a 128-bit key held in
// four CSRs. The datapath is a pipeline of 2*ROUNDS registered stages, one
// per half-round, and while the response side takes results one word can
// enter and one leave in every clock cycle. The clock rate is set by the
// single half-round adder chain in each stage. When the response side
// stalls, the whole pipeline holds; the first stage still takes a new word
// while it is empty, and once it holds a word a waiting result also holds
// off new requests. Words in flight are never dropped or duplicated. Key
// CSRs may only be rewritten while no word is in the pipeline; they reset
// to zero.
// ----------------------------------------------------------------------------
module xtea_block_cipher_top #(
   parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   xtea_req_if.sink              req_chan,
   xtea_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  xtea_pkg::key_idx_type csr_index,
   input  xtea_pkg::word_type    csr_wdata
);
   import xtea_pkg::*;

   localparam int STAGES = 2 * ROUNDS;

   key_array_type              key;
   logic                       advance;
   logic [STAGES-1:0]          stage_valid;
   block_type [STAGES-1:0]     stage_block;
   block_type                  req_block;

   // key words; the user must write them only while the pipeline is empty, the block does not enforce it
   xtea_keys u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key       (key)
   );

   // advance the whole pipeline unless a finished word is stuck at the output
   assign advance = !stage_valid[STAGES-1] || rsp_chan.ready;

   // take a new word whenever the first stage moves on or is empty
   assign req_chan.ready = advance || !stage_valid[0];

   always_comb begin
      req_block.cmd = cmd_type'(req_chan.command);
      req_block.v0  = req_chan.first_half;
      req_block.v1  = req_chan.second_half;
   end

   // first stage: half-round on the incoming word
   xtea_stage #(
      .STAGE  (0),
      .ROUNDS (ROUNDS)
   ) u_stage0 (
      .clock     (clock),
      .reset     (reset),
      .load_en   (req_chan.ready),
      .in_valid  (req_chan.valid),
      .in_block  (req_block),
      .key       (key),
      .out_valid (stage_valid[0]),
      .out_block (stage_block[0])
   );

   // remaining stages: hold together on a stall, shift together otherwise
   for (genvar s = 1; s < STAGES; s++) begin : g_stage
      xtea_stage #(
         .STAGE  (s),
         .ROUNDS (ROUNDS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .load_en   (advance),
         .in_valid  (stage_valid[s-1]),
         .in_block  (stage_block[s-1]),
         .key       (key),
         .out_valid (stage_valid[s]),
         .out_block (stage_block[s])
      );
   end

   // last stage register is the output register
   assign rsp_chan.valid           = stage_valid[STAGES-1];
   assign rsp_chan.out_first_half  = stage_block[STAGES-1].v0;
   assign rsp_chan.out_second_half = stage_block[STAGES-1].v1;

`ifndef SYNTHESIS
   a_shift_on_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> stage_valid[STAGES-1:1] == $past(stage_valid[STAGES-2:0]))
      else $error("pipeline valid bits did not shift on advance");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage_valid[STAGES-1:1]) && $stable(stage_block[STAGES-1:1]))
      else $error("pipeline changed during output stall");

   a_stage0_keep: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[0] && !advance) |=> stage_valid[0] && $stable(stage_block[0]))
      else $error("first stage lost a word during stall");

   a_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!advance && !stage_valid[0] && req_chan.valid) |=> stage_valid[0])
      else $error("word taken into empty first stage was lost");
`endif

endmodule

/* tb/sv/xtea_cipher_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XTEA cipher checker
// Watches the request, response and key CSR ports of the XTEA block cipher,
// computes the expected word for every accepted request from its own key
// copy, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module xtea_cipher_checker (
   input  logic                  clock,
   input  logic                  reset,
   xtea_req_if                   req_mon,
   xtea_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  xtea_pkg::key_idx_type csr_index,
   input  xtea_pkg::word_type    csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           pending_blocks
);
   import xtea_pkg::*;

   typedef struct packed {
      word_type first_half;
      word_type second_half;
   } half_pair_type;

   word_type      key_copy [KEY_WORDS];
   half_pair_type expected_words [$];
   int unsigned   error_total = 0;

   // full 32-round XTEA on one block under the current key copy
   function automatic half_pair_type run_cipher(input cmd_type cmd, input word_type v0_in,
                                                input word_type v1_in);
      word_type      v0;
      word_type      v1;
      word_type      sum;
      word_type      f;
      half_pair_type res;
      v0 = v0_in;
      v1 = v1_in;
      if (cmd == CMD_ENCIPHER) begin
         sum = '0;
         for (int r = 0; r < ROUNDS_DEF; r++) begin
            f   = ((v1 << 4) ^ (v1 >> 5)) + v1;
            v0  = v0 + (f ^ (sum + key_copy[sum[KEY_IDX_WIDTH-1:0]]));
            sum = sum + DELTA;
            f   = ((v0 << 4) ^ (v0 >> 5)) + v0;
            v1  = v1 + (f ^ (sum + key_copy[sum[KEY_SEL_HI_LSB +: KEY_IDX_WIDTH]]));
         end
      end else begin
         sum = DELTA * word_type'(ROUNDS_DEF);
         for (int r = 0; r < ROUNDS_DEF; r++) begin
            f   = ((v0 << 4) ^ (v0 >> 5)) + v0;
            v1  = v1 - (f ^ (sum + key_copy[sum[KEY_SEL_HI_LSB +: KEY_IDX_WIDTH]]));
            sum = sum - DELTA;
            f   = ((v1 << 4) ^ (v1 >> 5)) + v1;
            v0  = v0 - (f ^ (sum + key_copy[sum[KEY_IDX_WIDTH-1:0]]));
         end
      end
      res.first_half  = v0;
      res.second_half = v1;
      return res;
   endfunction

   always @(posedge clock) begin
      half_pair_type want;
      if (reset) begin
         expected_words.delete();
         for (int i = 0; i < KEY_WORDS; i++) key_copy[i] = '0;
      end else begin
         if (csr_we) key_copy[csr_index] = csr_wdata;

         // compare before pushing: a word taken now cannot leave in the same cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: response %h %h with no request outstanding", $realtime,
                           rsp_mon.out_first_half, rsp_mon.out_second_half);
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.out_first_half !== want.first_half ||
                   rsp_mon.out_second_half !== want.second_half) begin
                  error_total++;
                  if (error_total <= 10)
                     $display("%0t: mismatch expected %h %h actual %h %h", $realtime,
                              want.first_half, want.second_half,
                              rsp_mon.out_first_half, rsp_mon.out_second_half);
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(run_cipher(cmd_type'(req_mon.command),
                                                req_mon.first_half, req_mon.second_half));
      end
      fail_count     <= error_total;
      pending_blocks <= expected_words.size();
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Drives enciphers and deciphers through the cipher pipeline under several
// keys, with random idle bursts on both channels and one long response
// stall, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
   import xtea_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_WORDS      = 130;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   key_idx_type csr_index;
   word_type    csr_wdata;

   int unsigned fail_count;
   int unsigned pending_blocks;

   // idling control: idle_on allows random bursts, long_hold_armed asks the
   // response side for one long stall
   bit          idle_on         = 1'b1;
   bit          long_hold_armed = 1'b0;
   bit          long_hold_done  = 1'b0;
   int unsigned long_hold_left  = 0;
   int unsigned rsp_idle_left   = 0;

   xtea_req_if req_bus ();
   xtea_rsp_if rsp_bus ();

   xtea_block_cipher_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   xtea_cipher_checker cipher_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending_blocks (pending_blocks)
   );

   always #10 clock = ~clock;

   // hard stop in case the pipeline hangs
   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Response side: one long hold-off when armed, otherwise random idle
   // bursts while idling is on, else always ready.
   always @(posedge clock) begin
      if (long_hold_armed && !long_hold_done) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD_CYCLES;
      end
      if (long_hold_left != 0) begin
         long_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_idle_left != 0) begin
         rsp_idle_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         // this cycle starts the burst and the counter may extend it
         rsp_idle_left = $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offer one word and hold it until the pipeline takes it. Returns at the
   // accepting edge with valid still high, so a following word can go out
   // back to back when no random idle gap is inserted.
   task automatic send_block(input cmd_type cmd, input word_type v0, input word_type v1);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.first_half  <= v0;
      req_bus.second_half <= v1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_blocks != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four key words on consecutive edges; the pipeline is empty.
   task automatic load_key(input word_type k0, input word_type k1,
                           input word_type k2, input word_type k3);
      word_type words [KEY_WORDS];
      words = '{k0, k1, k2, k3};
      for (int i = 0; i < KEY_WORDS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= key_idx_type'(i);
         csr_wdata <= words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly uniform halves, with the corner values mixed in.
   function automatic word_type pick_half();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_phase(input int unsigned count);
      for (int unsigned n = 0; n < count; n++)
         send_block(cmd_type'($urandom_range(0, 1)), pick_half(), pick_half());
   endtask

   initial begin
      // request and CSR inputs known from time zero
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_ENCIPHER;
      req_bus.first_half  <= '0;
      req_bus.second_half <= '0;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // key never written: the cipher runs with the all-zero reset key
      send_block(CMD_ENCIPHER, 32'h0000_0000, 32'h0000_0000);
      send_block(CMD_DECIPHER, 32'h0000_0000, 32'h0000_0000);
      send_block(CMD_ENCIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(CMD_DECIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drained();

      // byte-sequence key, half extremes and alternating patterns
      load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
      send_block(CMD_ENCIPHER, 32'h4142_4344, 32'h4546_4748);
      send_block(CMD_ENCIPHER, 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(CMD_DECIPHER, 32'hFFFF_FFFF, 32'h0000_0000);
      send_block(CMD_ENCIPHER, 32'h8000_0000, 32'h7FFF_FFFF);
      send_block(CMD_DECIPHER, 32'h7FFF_FFFF, 32'h8000_0000);
      send_block(CMD_ENCIPHER, 32'hAAAA_AAAA, 32'h5555_5555);
      send_block(CMD_DECIPHER, 32'h5555_5555, 32'hAAAA_AAAA);
      wait_drained();

      // all-ones key
      load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(CMD_ENCIPHER, 32'h0000_0000, 32'h0000_0000);
      send_block(CMD_DECIPHER, 32'h0000_0000, 32'h0000_0000);
      send_block(CMD_ENCIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(CMD_DECIPHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_drained();

      // random traffic under a random key
      load_key($urandom, $urandom, $urandom, $urandom);
      run_phase(PHASE_WORDS);
      wait_drained();

      // mixed extreme key words; stall the response side long enough for
      // the pipeline to fill and push back on requests
      load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      long_hold_armed = 1'b1;
      run_phase(PHASE_WORDS);
      wait_drained();

      load_key($urandom, $urandom, $urandom, $urandom);
      run_phase(PHASE_WORDS);
      wait_drained();

      load_key($urandom, $urandom, $urandom, $urandom);
      run_phase(PHASE_WORDS);
      wait_drained();

      // last stretch at full rate: no idling on either side
      idle_on = 1'b0;
      load_key($urandom, $urandom, $urandom, $urandom);
      run_phase(PHASE_WORDS);
      wait_drained();

      // settle past the pipeline depth in case of stray responses
      repeat (2 * ROUNDS_DEF + 8) @(posedge clock);

      if (fail_count == 0 && pending_blocks == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/xtea_pkg.sv
rtl/core/xtea_req_if.sv
rtl/core/xtea_rsp_if.sv
rtl/core/xtea_keys.sv
rtl/core/xtea_stage.sv
rtl/core/xtea_block_cipher_top.sv
tb/sv/xtea_cipher_checker.sv
tb/sv/testbench.sv
